@@ sv/gbs_pkg.sv @@
// gbs_pkg: shared constants, codes and types of the grid bilinear sampler.
// No dependencies; used by gbs_seq, gbs_math and grid_bilinear_sampler.
package gbs_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_SIDE_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths
	localparam int POS_W     = 16;
	localparam int FRAC_BITS = 10;
	localparam int INT_W     = POS_W - FRAC_BITS;
	localparam int IDX_W     = 12;
	localparam int CELL_W    = 32;
	localparam int GRAD_W    = 34;
	localparam int SIDE_W    = 7;
	localparam int CFG_IDX_W = 1;

	// Width of the address arithmetic: (63+1)*127 + 127 + 1 stays below 2**14
	localparam int ADDR_CALC_W = 14;

	// Input function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;
	localparam logic [SIDE_W-1:0]    SIDE_RESET      = 7'd64;

	// Neighbor read order
	localparam logic [1:0] NB_00 = 2'd0;
	localparam logic [1:0] NB_10 = 2'd1;
	localparam logic [1:0] NB_01 = 2'd2;
	localparam logic [1:0] NB_11 = 2'd3;

	// Tag that travels with each memory read beat
	typedef struct packed {
		logic                 vld;
		logic [1:0]           sel;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic                 oor;
	} rd_tag_t;

endpackage

@@ sv/gbs_mem.sv @@
// gbs_mem: single-port synchronous cell memory with a registered read.
// No dependencies.
module gbs_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ sv/gbs_seq.sv @@
// gbs_seq: accepts beats, performs cell writes and sequences the four
// neighbor reads of a query. Depends on gbs_pkg.
module gbs_seq #(
	parameter int MAX_SIDE   = gbs_pkg::MAX_SIDE_DEF,
	parameter int VALUE_BITS = gbs_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 func,
	input  logic [gbs_pkg::IDX_W-1:0]            cell_index,
	input  logic [gbs_pkg::CELL_W-1:0]           cell_value,
	input  logic [gbs_pkg::POS_W-1:0]            pos_x,
	input  logic [gbs_pkg::POS_W-1:0]            pos_y,
	input  logic [gbs_pkg::SIDE_W-1:0]           grid_width,
	input  logic [gbs_pkg::SIDE_W-1:0]           grid_height,
	output logic                                 busy,
	output logic                                 mem_we,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] mem_addr,
	output logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] mem_wdata,
	output gbs_pkg::rd_tag_t                     tag
);

	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int AW       = $clog2(DEPTH);
	localparam int XW       = (AW > gbs_pkg::ADDR_CALC_W) ? AW : gbs_pkg::ADDR_CALC_W;
	localparam int SW       = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int SIDE_CAP = (MAX_SIDE < 127) ? MAX_SIDE : 127;
	localparam int SDW      = gbs_pkg::SIDE_W;
	localparam int FB       = gbs_pkg::FRAC_BITS;
	localparam int IW       = gbs_pkg::INT_W;
	localparam logic [XW:0]      DEPTH_V = (XW+1)'(DEPTH);
	localparam logic [SDW-1:0]   CAP_V   = SDW'(SIDE_CAP);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t            state_q;
	logic [1:0]        cnt_q;
	gbs_pkg::rd_tag_t  tag_q;
	logic [XW-1:0]     base_q;
	logic [SDW-1:0]    w_q;
	logic [FB-1:0]     fx_q, fy_q;
	logic              oor_q;

	logic              accept, is_query, idx_ok;
	logic [SDW-1:0]    w_eff, h_eff;
	logic [IW-1:0]     sx_in, sy_in;
	logic [FB-1:0]     fx_in, fy_in;
	logic              oor_in;
	logic [12:0]       prod;
	logic [XW-1:0]     base_in, rd_addr, wr_addr;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_query = (func == gbs_pkg::FUNC_QUERY);
	assign busy     = (state_q == ST_READ);

	// registers above the largest side act as that side
	assign w_eff = (grid_width  > CAP_V) ? CAP_V : grid_width;
	assign h_eff = (grid_height > CAP_V) ? CAP_V : grid_height;

	assign sx_in = pos_x[gbs_pkg::POS_W-1:FB];
	assign sy_in = pos_y[gbs_pkg::POS_W-1:FB];
	assign fx_in = pos_x[FB-1:0];
	assign fy_in = pos_y[FB-1:0];

	assign oor_in = (SDW'(sx_in) + SDW'(1) >= w_eff) || (SDW'(sy_in) + SDW'(1) >= h_eff);

	assign prod    = 13'(sy_in) * 13'(w_eff);
	assign base_in = XW'(prod) + XW'(sx_in);

	always_comb begin
		case (cnt_q)
			gbs_pkg::NB_10: rd_addr = base_q + XW'(1);
			gbs_pkg::NB_01: rd_addr = base_q + XW'(w_q);
			gbs_pkg::NB_11: rd_addr = base_q + XW'(w_q) + XW'(1);
			default:        rd_addr = base_q;
		endcase
	end

	assign wr_addr = XW'(cell_index);
	assign idx_ok  = ((XW+1)'(cell_index) < DEPTH_V);

	assign mem_we    = accept && !is_query && idx_ok;
	assign mem_wdata = cell_value[SW-1:0];

	always_comb begin
		if (state_q == ST_READ) begin
			mem_addr = rd_addr[AW-1:0];
		end else if (is_query) begin
			mem_addr = base_in[AW-1:0];
		end else begin
			mem_addr = wr_addr[AW-1:0];
		end
	end

	assign tag = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= gbs_pkg::NB_00;
			tag_q   <= '0;
		end else begin
			tag_q.vld <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q   <= ST_READ;
						cnt_q     <= gbs_pkg::NB_10;
						tag_q.vld <= 1'b1;
						tag_q.sel <= gbs_pkg::NB_00;
						tag_q.fx  <= fx_in;
						tag_q.fy  <= fy_in;
						tag_q.oor <= oor_in;
					end
				end
				ST_READ: begin
					tag_q.vld <= 1'b1;
					tag_q.sel <= cnt_q;
					tag_q.fx  <= fx_q;
					tag_q.fy  <= fy_q;
					tag_q.oor <= oor_q;
					cnt_q     <= cnt_q + 2'd1;
					if (cnt_q == gbs_pkg::NB_11) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query context, held through the read burst
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			base_q <= base_in;
			w_q    <= w_eff;
			fx_q   <= fx_in;
			fy_q   <= fy_in;
			oor_q  <= oor_in;
		end
	end

endmodule

@@ sv/gbs_math.sv @@
// gbs_math: collects the four neighbor beats and runs the interpolation and
// gradient pipeline (gather, first blend, second blend). Depends on gbs_pkg.
module gbs_math #(
	parameter int VALUE_BITS = gbs_pkg::VALUE_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] rdata,
	input  gbs_pkg::rd_tag_t                                 tag,
	output logic                                             done,
	output logic signed [gbs_pkg::CELL_W-1:0]                sample_value,
	output logic signed [gbs_pkg::GRAD_W-1:0]                grad_x,
	output logic signed [gbs_pkg::GRAD_W-1:0]                grad_y,
	output logic                                             out_of_range
);

	localparam int CW = gbs_pkg::CELL_W;
	localparam int DW = CW + 1;
	localparam int FB = gbs_pkg::FRAC_BITS;
	localparam int PW = CW + FB + 3;
	localparam int QW = DW + FB + 3;
	localparam logic signed [FB+1:0] ONE = (FB+2)'(1 << FB);

	logic signed [CW-1:0] rd_val;
	logic signed [CW-1:0] v00_q, v10_q, v01_q;

	logic                 valid_s1, oor_s1;
	logic signed [CW-1:0] v00_s1, v10_s1, v01_s1, v11_s1;
	logic [FB-1:0]        fx_s1, fy_s1;

	logic                 valid_s2, oor_s2;
	logic signed [CW-1:0] top_s2, bot_s2;
	logic signed [DW-1:0] gx_s2, gy_s2;
	logic [FB-1:0]        fy_s2;

	logic signed [FB+1:0] wbx, wax, wby, way, wby2, way2;
	logic signed [DW-1:0] dx0, dx1, dy0, dy1;
	logic signed [PW-1:0] top_sum, bot_sum, val_sum;
	logic signed [QW-1:0] gx_sum, gy_sum;

	assign rd_val = CW'($signed(rdata));

	// gather: first three neighbors held, fourth goes straight into stage 1
	always_ff @(posedge clk) begin
		if (tag.vld) begin
			case (tag.sel)
				gbs_pkg::NB_00: v00_q <= rd_val;
				gbs_pkg::NB_10: v10_q <= rd_val;
				gbs_pkg::NB_01: v01_q <= rd_val;
				default: begin
					v00_s1 <= v00_q;
					v10_s1 <= v10_q;
					v01_s1 <= v01_q;
					v11_s1 <= rd_val;
					fx_s1  <= tag.fx;
					fy_s1  <= tag.fy;
					oor_s1 <= tag.oor;
				end
			endcase
		end
	end

	// first blend: row values and both gradients, floored after >>> 10
	assign wbx = $signed({2'b00, fx_s1});
	assign wax = ONE - wbx;
	assign wby = $signed({2'b00, fy_s1});
	assign way = ONE - wby;

	assign dx0 = DW'(v10_s1) - DW'(v00_s1);
	assign dx1 = DW'(v11_s1) - DW'(v01_s1);
	assign dy0 = DW'(v01_s1) - DW'(v00_s1);
	assign dy1 = DW'(v11_s1) - DW'(v10_s1);

	assign top_sum = PW'(v00_s1) * PW'(wax) + PW'(v10_s1) * PW'(wbx);
	assign bot_sum = PW'(v01_s1) * PW'(wax) + PW'(v11_s1) * PW'(wbx);
	assign gx_sum  = QW'(dx0) * QW'(way) + QW'(dx1) * QW'(wby);
	assign gy_sum  = QW'(dy0) * QW'(wax) + QW'(dy1) * QW'(wbx);

	always_ff @(posedge clk) begin
		top_s2 <= CW'(top_sum >>> FB);
		bot_s2 <= CW'(bot_sum >>> FB);
		gx_s2  <= DW'(gx_sum >>> FB);
		gy_s2  <= DW'(gy_sum >>> FB);
		fy_s2  <= fy_s1;
		oor_s2 <= oor_s1;
	end

	// second blend: across rows
	assign wby2    = $signed({2'b00, fy_s2});
	assign way2    = ONE - wby2;
	assign val_sum = PW'(top_s2) * PW'(way2) + PW'(bot_s2) * PW'(wby2);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			sample_value <= oor_s2 ? '0 : CW'(val_sum >>> FB);
			grad_x       <= oor_s2 ? '0 : gbs_pkg::GRAD_W'(gx_s2);
			grad_y       <= oor_s2 ? '0 : gbs_pkg::GRAD_W'(gy_s2);
			out_of_range <= oor_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= tag.vld && (tag.sel == gbs_pkg::NB_11);
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

endmodule

@@ sv/grid_bilinear_sampler.sv @@
// grid_bilinear_sampler: top level; configuration registers plus the cell
// memory, read sequencer and blend pipeline. Depends on gbs_pkg, gbs_mem,
// gbs_seq and gbs_math.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | start, busy          | func, cell_index, cell_value, pos_x, pos_y
//  result   | done (one cycle)     | sample_value, grad_x, grad_y, out_of_range
//  config   | cfg_we               | cfg_index, cfg_data
//
// A beat is taken on a rising edge with start high and busy low.
// A cell write gives no result; busy stays low.
// A query holds busy while its remaining neighbor reads are issued, so no beat is
// taken meanwhile: the four neighbor cells come one a cycle out of the single
// memory port. done pulses for one cycle, after the read, gather, blend and result registers.
// Reset clears control only; cells read as garbage until written.
// The result side has no back-pressure; the pipeline never waits on it.
module grid_bilinear_sampler #(
	parameter int MAX_SIDE   = gbs_pkg::MAX_SIDE_DEF,
	parameter int VALUE_BITS = gbs_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input beat
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 func,
	input  logic [gbs_pkg::IDX_W-1:0]            cell_index,
	input  logic signed [gbs_pkg::CELL_W-1:0]    cell_value,
	input  logic [gbs_pkg::POS_W-1:0]            pos_x,
	input  logic [gbs_pkg::POS_W-1:0]            pos_y,
	// result beat
	output logic                                 done,
	output logic signed [gbs_pkg::CELL_W-1:0]    sample_value,
	output logic signed [gbs_pkg::GRAD_W-1:0]    grad_x,
	output logic signed [gbs_pkg::GRAD_W-1:0]    grad_y,
	output logic                                 out_of_range,
	// configuration
	input  logic                                 cfg_we,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gbs_pkg::SIDE_W-1:0]           cfg_data
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	logic [gbs_pkg::SIDE_W-1:0] grid_width_q, grid_height_q;

	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [SW-1:0]    mem_wdata, mem_rdata;
	gbs_pkg::rd_tag_t tag;

	// configuration registers; to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gbs_pkg::SIDE_RESET;
			grid_height_q <= gbs_pkg::SIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gbs_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				gbs_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accept, write and neighbor read sequencing
	gbs_seq #(
		.MAX_SIDE   (MAX_SIDE),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.cell_index  (cell_index),
		.cell_value  (cell_value),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.busy        (busy),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.tag         (tag)
	);

	// cell store, stored at the reduced value width
	gbs_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// blend pipeline and result register
	gbs_math #(
		.VALUE_BITS (VALUE_BITS)
	) u_math (
		.clk          (clk),
		.arst_n       (arst_n),
		.rdata        (mem_rdata),
		.tag          (tag),
		.done         (done),
		.sample_value (sample_value),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.out_of_range (out_of_range)
	);

endmodule

@@ tb/grid_bilinear_sampler_test.sv @@
`timescale 1ns / 100ps
// grid_bilinear_sampler_test: self-checking testbench for the grid bilinear sampler.
// Needs gbs_pkg and the grid_bilinear_sampler RTL; checks every result against an
// in-bench mirror of the grid and the blend arithmetic.
module grid_bilinear_sampler_test;

	localparam int     GRID_CELLS    = 1 << gbs_pkg::IDX_W;
	localparam longint ONE_Q10       = longint'(1) << gbs_pkg::FRAC_BITS;
	localparam int     SETTLE_CYCLES = 16;      // margin after draining for the tail of the pipe to settle
	localparam int     DRAIN_LIMIT   = 64;
	localparam int     CYCLE_LIMIT   = 250000;
	localparam int     BEATS_PER_SET = 20;
	localparam int     N_SETTINGS    = 9;
	localparam int     PRINT_CAP     = 50;

	// one input beat, and one result beat
	typedef struct {
		logic                              func;
		logic [gbs_pkg::IDX_W-1:0]         cell_index;
		logic signed [gbs_pkg::CELL_W-1:0] cell_value;
		logic [gbs_pkg::POS_W-1:0]         pos_x;
		logic [gbs_pkg::POS_W-1:0]         pos_y;
	} grid_beat_t;

	typedef struct {
		logic signed [gbs_pkg::CELL_W-1:0] sample_value;
		logic signed [gbs_pkg::GRAD_W-1:0] grad_x;
		logic signed [gbs_pkg::GRAD_W-1:0] grad_y;
		logic                              out_of_range;
	} grid_sample_t;

	// grid settings walked after the directed part: extremes, oversized, degenerate
	localparam logic [gbs_pkg::SIDE_W-1:0] SET_W [N_SETTINGS] = '{7'd2, 7'd127, 7'd37, 7'd0,
		7'd64, 7'd2, 7'd64, 7'd100, 7'd64};
	localparam logic [gbs_pkg::SIDE_W-1:0] SET_H [N_SETTINGS] = '{7'd2, 7'd127, 7'd19, 7'd64,
		7'd1, 7'd64, 7'd2, 7'd50, 7'd64};
	localparam int IDLE_MIX [3] = '{0, 58, 35};

	logic                              clk = 1'b1;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic                              func = gbs_pkg::FUNC_WRITE;
	logic [gbs_pkg::IDX_W-1:0]         cell_index = '0;
	logic signed [gbs_pkg::CELL_W-1:0] cell_value = '0;
	logic [gbs_pkg::POS_W-1:0]         pos_x = '0;
	logic [gbs_pkg::POS_W-1:0]         pos_y = '0;
	logic                              done;
	logic signed [gbs_pkg::CELL_W-1:0] sample_value;
	logic signed [gbs_pkg::GRAD_W-1:0] grad_x;
	logic signed [gbs_pkg::GRAD_W-1:0] grad_y;
	logic                              out_of_range;
	logic                              cfg_we = 1'b0;
	logic [gbs_pkg::CFG_IDX_W-1:0]     cfg_index = gbs_pkg::CFG_GRID_WIDTH;
	logic [gbs_pkg::SIDE_W-1:0]        cfg_data = '0;

	grid_bilinear_sampler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.cell_index   (cell_index),
		.cell_value   (cell_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.done         (done),
		.sample_value (sample_value),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.out_of_range (out_of_range),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Stimulus side: beats waiting to go out, and the cells that some queued write
	// already covers (an in-range query is only queued once its four neighbors are covered).
	grid_beat_t   pending_beats [$];
	bit           cell_seeded [GRID_CELLS];
	int           sender_idle_pct = 0;
	int           writes_queued = 0;
	int           queries_queued = 0;

	// Mirror of the block: grid contents and the two side registers.
	longint       grid_mirror [GRID_CELLS];
	logic [gbs_pkg::SIDE_W-1:0] mirror_width = gbs_pkg::SIDE_RESET;
	logic [gbs_pkg::SIDE_W-1:0] mirror_height = gbs_pkg::SIDE_RESET;
	grid_sample_t expected_samples [$];

	int           mismatches = 0;
	int           samples_seen = 0;
	int           oor_seen = 0;
	int           cycle_count = 0;
	grid_beat_t   cur_beat;
	grid_sample_t want_sample;

	task automatic report_mismatch(input string what, input logic signed [63:0] got,
		input logic signed [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
		end
	endtask

	// registers above the grid limit act as the limit
	function automatic int eff_side(input logic [gbs_pkg::SIDE_W-1:0] r);
		return (r > gbs_pkg::MAX_SIDE_DEF) ? gbs_pkg::MAX_SIDE_DEF : int'(r);
	endfunction

	// floor(((1-w)*a + w*b) / 1024); >>> on a signed longint floors
	function automatic longint lerp_q10(input longint a, input longint b, input longint w);
		return (a * (ONE_Q10 - w) + b * w) >>> gbs_pkg::FRAC_BITS;
	endfunction

	// Applies one accepted beat to the mirror; a query queues its expected sample.
	function automatic void predict_sample(input grid_beat_t b);
		grid_sample_t r;
		int           sx, sy, w, h, base;
		longint       fx, fy, v00, v10, v01, v11, top, bot, val, gx, gy;
		if (b.func == gbs_pkg::FUNC_WRITE) begin
			grid_mirror[b.cell_index] = longint'(b.cell_value);
			return;
		end
		sx = int'(b.pos_x[gbs_pkg::POS_W-1:gbs_pkg::FRAC_BITS]);
		sy = int'(b.pos_y[gbs_pkg::POS_W-1:gbs_pkg::FRAC_BITS]);
		fx = longint'(b.pos_x[gbs_pkg::FRAC_BITS-1:0]);
		fy = longint'(b.pos_y[gbs_pkg::FRAC_BITS-1:0]);
		w = eff_side(mirror_width);
		h = eff_side(mirror_height);
		if (sx + 1 >= w || sy + 1 >= h) begin
			// neighborhood leaves the grid, even with a zero fraction
			r.sample_value = '0;
			r.grad_x = '0;
			r.grad_y = '0;
			r.out_of_range = 1'b1;
		end else begin
			base = sy * w + sx;
			v00 = grid_mirror[base];
			v10 = grid_mirror[base + 1];
			v01 = grid_mirror[base + w];
			v11 = grid_mirror[base + w + 1];
			top = lerp_q10(v00, v10, fx);
			bot = lerp_q10(v01, v11, fx);
			val = lerp_q10(top, bot, fy);
			gx = lerp_q10(v10 - v00, v11 - v01, fy);
			gy = lerp_q10(v01 - v00, v11 - v10, fx);
			r.sample_value = val[gbs_pkg::CELL_W-1:0];
			r.grad_x = gx[gbs_pkg::GRAD_W-1:0];
			r.grad_y = gy[gbs_pkg::GRAD_W-1:0];
			r.out_of_range = 1'b0;
		end
		expected_samples.push_back(r);
	endfunction

	// cell values lean on the extremes now and then
	function automatic logic [gbs_pkg::CELL_W-1:0] rand_cell();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [gbs_pkg::FRAC_BITS-1:0] rand_frac();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return gbs_pkg::FRAC_BITS'($urandom);
		endcase
	endfunction

	task automatic push_write(input int idx, input logic [gbs_pkg::CELL_W-1:0] value,
		input logic [gbs_pkg::POS_W-1:0] px, input logic [gbs_pkg::POS_W-1:0] py);
		grid_beat_t b;
		b.func = gbs_pkg::FUNC_WRITE;
		b.cell_index = gbs_pkg::IDX_W'(idx);
		b.cell_value = value;
		b.pos_x = px;
		b.pos_y = py;
		cell_seeded[idx] = 1'b1;
		pending_beats.push_back(b);
		writes_queued++;
	endtask

	task automatic push_query(input logic [gbs_pkg::POS_W-1:0] px,
		input logic [gbs_pkg::POS_W-1:0] py, input logic [gbs_pkg::IDX_W-1:0] idx,
		input logic [gbs_pkg::CELL_W-1:0] value);
		grid_beat_t b;
		b.func = gbs_pkg::FUNC_QUERY;
		b.cell_index = idx;
		b.cell_value = value;
		b.pos_x = px;
		b.pos_y = py;
		pending_beats.push_back(b);
		queries_queued++;
	endtask

	task automatic seed_cell(input int idx);
		if (!cell_seeded[idx]) begin
			push_write(idx, rand_cell(), gbs_pkg::POS_W'($urandom), gbs_pkg::POS_W'($urandom));
		end
	endtask

	// Query at (px,py) under the current setting; uncovered neighbors get written first.
	task automatic add_query(input logic [gbs_pkg::POS_W-1:0] px,
		input logic [gbs_pkg::POS_W-1:0] py);
		int sx, sy, w, h, base;
		sx = int'(px[gbs_pkg::POS_W-1:gbs_pkg::FRAC_BITS]);
		sy = int'(py[gbs_pkg::POS_W-1:gbs_pkg::FRAC_BITS]);
		w = eff_side(mirror_width);
		h = eff_side(mirror_height);
		if (sx + 1 < w && sy + 1 < h) begin
			base = sy * w + sx;
			seed_cell(base);
			seed_cell(base + 1);
			seed_cell(base + w);
			seed_cell(base + w + 1);
		end
		push_query(px, py, gbs_pkg::IDX_W'($urandom), $urandom);
	endtask

	// Mostly in-range queries with random content; the rest out-of-range ones,
	// raw positions and stray writes anywhere in the store.
	task automatic random_set(input int count);
		int                        pick, w, h, lo;
		logic [gbs_pkg::POS_W-1:0] px, py;
		w = eff_side(mirror_width);
		h = eff_side(mirror_height);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 65 && w >= 2 && h >= 2) begin
				px = {6'($urandom_range(w - 2, 0)), rand_frac()};
				py = {6'($urandom_range(h - 2, 0)), rand_frac()};
				add_query(px, py);
			end else if (pick < 80) begin
				// push one axis past the last full cell
				px = gbs_pkg::POS_W'($urandom);
				py = gbs_pkg::POS_W'($urandom);
				if ($urandom_range(1)) begin
					lo = (w > 0) ? w - 1 : 0;
					px = {6'($urandom_range(63, lo)), rand_frac()};
				end else begin
					lo = (h > 0) ? h - 1 : 0;
					py = {6'($urandom_range(63, lo)), rand_frac()};
				end
				add_query(px, py);
			end else if (pick < 85) begin
				add_query(gbs_pkg::POS_W'($urandom), gbs_pkg::POS_W'($urandom));
			end else begin
				push_write($urandom_range(GRID_CELLS - 1), rand_cell(),
					gbs_pkg::POS_W'($urandom), gbs_pkg::POS_W'($urandom));
			end
		end
	endtask

	// Idle point: all beats taken, every sample back, then the tail of the pipe.
	task automatic wait_drained();
		int waited;
		@(negedge clk);
		while (pending_beats.size() != 0 || start) begin
			@(negedge clk);
		end
		waited = 0;
		while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_samples.size() != 0) begin
			report_mismatch("samples never returned", 0, expected_samples.size());
			expected_samples.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [gbs_pkg::CFG_IDX_W-1:0] idx,
		input logic [gbs_pkg::SIDE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gbs_pkg::CFG_GRID_WIDTH) begin
			mirror_width = value;
		end else begin
			mirror_height = value;
		end
	endtask

	// Driver: a beat goes out when start is high and busy is low at the edge;
	// the next one is offered on that same edge unless the sender idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_sample(cur_beat);
			end
			if (!start || !busy) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					cur_beat = pending_beats.pop_front();
					start <= 1'b1;
					func <= cur_beat.func;
					cell_index <= cur_beat.cell_index;
					cell_value <= cur_beat.cell_value;
					pos_x <= cur_beat.pos_x;
					pos_y <= cur_beat.pos_y;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done is a one-cycle strobe, so every pulse is a result beat.
	always @(posedge clk) begin
		if (arst_n && done) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				report_mismatch("sample with nothing pending", sample_value, 0);
			end else begin
				want_sample = expected_samples.pop_front();
				if (sample_value !== want_sample.sample_value)
					report_mismatch("sample_value", sample_value, want_sample.sample_value);
				if (grad_x !== want_sample.grad_x)
					report_mismatch("grad_x", grad_x, want_sample.grad_x);
				if (grad_y !== want_sample.grad_y)
					report_mismatch("grad_y", grad_y, want_sample.grad_y);
				if (out_of_range !== want_sample.out_of_range)
					report_mismatch("out_of_range", out_of_range, want_sample.out_of_range);
				if (want_sample.out_of_range)
					oor_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("grid_bilinear_sampler_test NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = IDLE_MIX[2];

		// Directed, reset setting 64 x 64. Extreme cells around the origin, with the
		// position fields of writes and the address fields of queries set but ignored.
		push_write(0, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
		push_write(1, 32'h8000_0000, 16'h0000, 16'h0000);
		push_write(64, 32'hFFFF_FFFF, 16'hA5A5, 16'h5A5A);
		push_write(65, 32'h8000_0000, 16'h0000, 16'hFFFF);
		push_query(16'h0000, 16'h0000, '1, 32'hFFFF_FFFF);
		push_query(16'h03FF, 16'h03FF, '0, 32'h0);
		push_query(16'h0200, 16'h0155, 12'hABC, 32'h1234_5678);
		push_query(16'h0001, 16'h03FF, '1, 32'h8000_0000);
		// far corner of a full grid: highest cell address and top position bits
		push_write(4030, 32'h8000_0000, 16'h0000, 16'h0000);
		push_write(4031, 32'h7FFF_FFFF, 16'h0000, 16'h0000);
		push_write(4094, 32'h7FFF_FFFF, 16'h0000, 16'h0000);
		push_write(4095, 32'h8000_0000, 16'h0000, 16'h0000);
		push_query(16'hFBFF, 16'hFBFF, '0, 32'h0);
		push_query(16'hF800, 16'hF800, '0, 32'h0);
		// neighborhood off the grid, on each axis, both, and with zero fraction
		push_query(16'hFC00, 16'h0000, '0, 32'h0);
		push_query(16'h0000, 16'hFC00, '0, 32'h0);
		push_query(16'hFFFF, 16'hFFFF, '1, 32'hFFFF_FFFF);
		push_query(16'hFBFF, 16'hFC00, '0, 32'h0);
		wait_drained();

		for (int s = 0; s < N_SETTINGS; s++) begin
			write_register(gbs_pkg::CFG_GRID_WIDTH, SET_W[s]);
			write_register(gbs_pkg::CFG_GRID_HEIGHT, SET_H[s]);
			sender_idle_pct = IDLE_MIX[s % 3];
			random_set(BEATS_PER_SET);
			wait_drained();
		end

		$display("covered %0d cell writes and %0d queries over %0d grid settings",
			writes_queued, queries_queued, N_SETTINGS + 1);
		$display("%0d samples checked, %0d of them off the grid, %0d mismatches",
			samples_seen, oor_seen, mismatches);
		if (mismatches == 0) begin
			$display("grid_bilinear_sampler_test OK");
		end else begin
			$display("grid_bilinear_sampler_test NOT OK");
		end
		$finish;
	end

endmodule
